/* hw/rtl/idl_pkg.sv */
package idl_pkg;
  localparam int Capacity = 256;
  localparam int PtrW = 9;    // entry index plus null
  localparam int IdxW = 8;    // entry index
  localparam logic [PtrW-1:0] NilLink = 9'd256;

  localparam logic [1:0] ModeRead   = 2'd0;
  localparam logic [1:0] ModeInsert = 2'd1;
  localparam logic [1:0] ModeRemove = 2'd2;

  // Datapath commands issued by the controller.
  localparam logic [3:0] CmdNone    = 4'd0;
  localparam logic [3:0] CmdLoad    = 4'd1;  // latch item, set walk origin
  localparam logic [3:0] CmdRdCur   = 4'd2;  // issue read of cur links/value
  localparam logic [3:0] CmdStep    = 4'd3;  // follow one link
  localparam logic [3:0] CmdCapture = 4'd4;  // capture read data of cur
  localparam logic [3:0] CmdRdFree  = 4'd5;  // read next link of free head
  localparam logic [3:0] CmdIns1    = 4'd6;  // write new entry
  localparam logic [3:0] CmdIns2    = 4'd7;  // patch neighbors
  localparam logic [3:0] CmdRem1    = 4'd8;  // patch neighbors
  localparam logic [3:0] CmdRem2    = 4'd9;  // push removed entry on free list
  localparam logic [3:0] CmdFail    = 4'd10;
  localparam logic [3:0] CmdInitFl  = 4'd11; // one step of free list build

  typedef struct packed {
    logic [3:0] op;
  } idl_cmd_t;

  typedef struct packed {
    logic       init_done;
    logic       steps_zero;  // walk counter exhausted
    logic       in_range;    // target index below count
    logic       full;
    logic       direct_end;  // insert at 0 or -1
    logic [1:0] mode;
  } idl_stat_t;
endpackage

/* hw/rtl/indexed_deque_list.sv */
// Bounded doubly linked list of up to 256 signed 32-bit values. Each input
// transaction reads (mode 0), inserts (mode 1) or removes (mode 2) at a signed
// position: non-negative from the front, negative from the back, -1 last.
// Each transaction returns one result with ok, the value read or removed and
// the element count. After reset a free-list build pass over all 256 entries
// runs before the first transaction is taken. A seek walks up to 255 links
// from the chosen end; the walk through the link memory, with a registered
// read for each link, sets the time. The next transaction is taken only after
// the result of the last one has been taken.
module indexed_deque_list import idl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mode[1:0], position[11:2], value[43:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // ok[0], read_value[32:1], count[41:33]
);
  idl_cmd_t        cmd;
  idl_stat_t       stat;
  logic            ok;
  logic [31:0]     rv;
  logic [PtrW-1:0] cnt;

  idl_ctrl u_ctrl (
    .clk, .rst_n, .stat, .cmd,
    .in_fire(in_tvalid & in_tready), .in_rdy(in_tready),
    .out_taken(out_tvalid & out_tready), .out_vld(out_tvalid));

  idl_datapath u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_mode(in_tdata[1:0]), .in_position(in_tdata[11:2]),
    .in_value(in_tdata[43:12]),
    .res_ok(ok), .res_value(rv), .res_count(cnt));

  assign out_tdata = {6'd0, cnt, rv, ok};
endmodule

/* hw/rtl/idl_ram.sv */
module idl_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/idl_datapath.sv */
module idl_datapath import idl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  idl_cmd_t        cmd,
  output idl_stat_t       stat,
  input  logic [1:0]      in_mode,
  input  logic [9:0]      in_position,
  input  logic [31:0]     in_value,
  output logic            res_ok,
  output logic [31:0]     res_value,
  output logic [PtrW-1:0] res_count
);
  // Item registers.
  logic [1:0]      mode_r;
  logic            fwd_r;
  logic [31:0]     val_r;
  logic [9:0]      steps_r;
  logic            in_range_r;
  logic            direct_r;
  // List registers.
  logic [PtrW-1:0] head_r, tail_r, free_r, count_r, cur_r;
  logic [PtrW-1:0] cap_next_r, cap_prev_r;
  logic [31:0]     cap_val_r;
  logic [IdxW:0]   init_r;
  logic            init_done_r;
  logic            ok_r;
  logic [31:0]     rv_r;
  // Neighbors of the new entry, held from the write cycle for the patch cycle.
  logic [PtrW-1:0] ins_a_r, ins_b_r;

  // Memory ports.
  logic            v_we, n_we, p_we;
  logic [IdxW-1:0] v_wa, n_wa, p_wa, rd_a;
  logic [31:0]     v_wd, v_rd;
  logic [PtrW-1:0] n_wd, p_wd, n_rd, p_rd;
  // The neighbor patches need two writes to each link memory; second uses
  // a shadow cycle, so one write per memory per cycle.

  idl_ram #(.Width(32), .Depth(Capacity)) u_val (
    .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(rd_a), .rdata(v_rd));
  idl_ram #(.Width(PtrW), .Depth(Capacity)) u_next (
    .clk, .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(rd_a), .rdata(n_rd));
  idl_ram #(.Width(PtrW), .Depth(Capacity)) u_prev (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(rd_a), .rdata(p_rd));

  // Decode of the signed position.
  logic            pos_neg;
  logic [9:0]      pos_mag;     // steps from chosen end for read/remove
  logic [9:0]      ins_mag;     // steps to the anchor for insert
  logic            ins_fwd;
  always_comb begin
    pos_neg = in_position[9];
    pos_mag = pos_neg ? ~in_position : in_position;
    if (in_position == 10'd0) begin
      ins_fwd = 1'b1;
      ins_mag = 10'd0;
    end else if (in_position == 10'h3ff) begin
      ins_fwd = 1'b0;
      ins_mag = 10'd0;
    end else if (!pos_neg) begin
      ins_fwd = 1'b1;
      ins_mag = in_position - 10'd1;
    end else begin
      ins_fwd = 1'b0;
      ins_mag = pos_mag - 10'd1;
    end
  end

  // Walk and anchor pointers.
  logic [PtrW-1:0] a_ptr, b_ptr;
  always_comb begin
    a_ptr = NilLink;
    b_ptr = NilLink;
    if (direct_r) begin
      if (fwd_r) begin
        b_ptr = head_r;
      end else begin
        a_ptr = tail_r;
      end
    end else if (fwd_r) begin
      a_ptr = cur_r;
      b_ptr = cap_next_r;
    end else begin
      a_ptr = cap_prev_r;
      b_ptr = cur_r;
    end
  end

  always_comb begin
    rd_a = cur_r[IdxW-1:0];
    if (cmd.op == CmdRdFree) begin
      rd_a = free_r[IdxW-1:0];
    end
  end

  // Memory writes by command.
  always_comb begin
    v_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
    v_wa = free_r[IdxW-1:0]; n_wa = free_r[IdxW-1:0]; p_wa = free_r[IdxW-1:0];
    v_wd = val_r; n_wd = b_ptr; p_wd = a_ptr;
    case (cmd.op)
      CmdInitFl: begin
        n_we = 1'b1;
        n_wa = init_r[IdxW-1:0];
        n_wd = PtrW'(init_r) + PtrW'(1);
      end
      CmdIns1: begin
        v_we = 1'b1; n_we = 1'b1; p_we = 1'b1;
      end
      CmdIns2: begin
        // cur_r now holds the new entry; free_r advanced.
        n_we = (ins_a_r != NilLink);
        n_wa = ins_a_r[IdxW-1:0];
        n_wd = cur_r;
        p_we = (ins_b_r != NilLink);
        p_wa = ins_b_r[IdxW-1:0];
        p_wd = cur_r;
      end
      CmdRem1: begin
        n_we = (cap_prev_r != NilLink);
        n_wa = cap_prev_r[IdxW-1:0];
        n_wd = cap_next_r;
        p_we = (cap_next_r != NilLink);
        p_wa = cap_next_r[IdxW-1:0];
        p_wd = cap_prev_r;
      end
      CmdRem2: begin
        n_we = 1'b1; n_wa = cur_r[IdxW-1:0]; n_wd = free_r;
        p_we = 1'b1; p_wa = cur_r[IdxW-1:0]; p_wd = NilLink;
      end
      default: begin
      end
    endcase
  end

  // Register updates by command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NilLink;
      tail_r      <= NilLink;
      free_r      <= '0;
      count_r     <= '0;
      init_r      <= '0;
      init_done_r <= 1'b0;
    end else begin
      case (cmd.op)
        CmdInitFl: begin
          init_r <= init_r + (IdxW+1)'(1);
          if (init_r == (IdxW+1)'(Capacity - 1)) begin
            init_done_r <= 1'b1;
          end
        end
        CmdLoad: begin
          mode_r <= in_mode;
          val_r  <= in_value;
          ok_r   <= 1'b0;
          rv_r   <= '0;
          if (in_mode == ModeInsert) begin
            fwd_r    <= ins_fwd;
            steps_r  <= ins_mag;
            direct_r <= (in_position == 10'd0) || (in_position == 10'h3ff);
            in_range_r <= (ins_mag[9] == 1'b0) && (ins_mag < {1'b0, count_r});
            cur_r    <= ins_fwd ? head_r : tail_r;
          end else begin
            fwd_r    <= !pos_neg;
            steps_r  <= pos_mag;
            direct_r <= 1'b0;
            in_range_r <= (pos_mag[9] == 1'b0) && (pos_mag < {1'b0, count_r});
            cur_r    <= pos_neg ? tail_r : head_r;
          end
        end
        CmdStep: begin
          cur_r   <= fwd_r ? n_rd : p_rd;
          steps_r <= steps_r - 10'd1;
        end
        CmdCapture: begin
          cap_next_r <= n_rd;
          cap_prev_r <= p_rd;
          cap_val_r  <= v_rd;
        end
        CmdRdFree: begin
        end
        CmdIns1: begin
          ins_a_r <= a_ptr;
          ins_b_r <= b_ptr;
          cur_r   <= free_r;
          free_r  <= n_rd;
          count_r <= count_r + PtrW'(1);
          ok_r    <= 1'b1;
          if (a_ptr == NilLink) head_r <= free_r;
          if (b_ptr == NilLink) tail_r <= free_r;
        end
        CmdIns2: begin
        end
        CmdRem1: begin
          ok_r <= 1'b1;
          rv_r <= cap_val_r;
          if (cap_next_r == NilLink) tail_r <= cap_prev_r;
          if (cap_prev_r == NilLink) head_r <= cap_next_r;
        end
        CmdRem2: begin
          free_r  <= cur_r;
          count_r <= count_r - PtrW'(1);
        end
        CmdFail: begin
          if (mode_r == ModeRead && in_range_r) begin
            ok_r <= 1'b1;
            rv_r <= cap_val_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.init_done  = init_done_r;
  assign stat.steps_zero = (steps_r == 10'd0);
  assign stat.in_range   = in_range_r;
  assign stat.full       = (count_r == PtrW'(Capacity));
  assign stat.direct_end = direct_r;
  assign stat.mode       = mode_r;

  assign res_ok    = ok_r;
  assign res_value = rv_r;
  assign res_count = count_r;
endmodule

/* hw/rtl/idl_ctrl.sv */
module idl_ctrl import idl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  idl_stat_t stat,
  output idl_cmd_t  cmd,
  input  logic      in_fire,
  output logic      in_rdy,
  input  logic      out_taken,
  output logic      out_vld
);
  localparam logic [3:0] StInit  = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StCheck = 4'd2;
  localparam logic [3:0] StRd    = 4'd3;
  localparam logic [3:0] StWalk  = 4'd4;
  localparam logic [3:0] StCap   = 4'd5;
  localparam logic [3:0] StAct   = 4'd6;
  localparam logic [3:0] StFree  = 4'd7;
  localparam logic [3:0] StIns1  = 4'd8;
  localparam logic [3:0] StIns2  = 4'd9;
  localparam logic [3:0] StRem2  = 4'd10;
  localparam logic [3:0] StDone  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       vld_r, vld_nxt;

  // Sequencer: seek by walking links, then read the entry or patch pointers.
  always_comb begin
    state_nxt = state_r;
    vld_nxt   = vld_r;
    cmd.op    = CmdNone;
    if (out_taken) vld_nxt = 1'b0;
    case (state_r)
      StInit: begin
        if (stat.init_done) state_nxt = StIdle;
        else cmd.op = CmdInitFl;
      end
      StIdle: begin
        if (in_fire) begin
          cmd.op = CmdLoad;
          state_nxt = StCheck;
        end
      end
      StCheck: begin
        if (stat.mode == ModeInsert) begin
          if (stat.full) state_nxt = StDone;
          else if (stat.direct_end) state_nxt = StFree;
          else if (stat.in_range) state_nxt = StRd;
          else state_nxt = StDone;
        end else if (stat.mode == ModeRead || stat.mode == ModeRemove) begin
          state_nxt = stat.in_range ? StRd : StDone;
        end else begin
          state_nxt = StDone;
        end
      end
      StRd: begin
        cmd.op = CmdRdCur;
        state_nxt = stat.steps_zero ? StCap : StWalk;
      end
      StWalk: begin
        cmd.op = CmdStep;
        state_nxt = StRd;
      end
      StCap: begin
        cmd.op = CmdCapture;
        state_nxt = StAct;
      end
      StAct: begin
        if (stat.mode == ModeRemove) begin
          cmd.op = CmdRem1;
          state_nxt = StRem2;
        end else if (stat.mode == ModeInsert) begin
          state_nxt = StFree;
        end else begin
          cmd.op = CmdFail;
          state_nxt = StDone;
        end
      end
      // The next link of the free head is on the read port in the cycle after.
      StFree: begin
        cmd.op = CmdRdFree;
        state_nxt = StIns1;
      end
      StIns1: begin
        cmd.op = CmdIns1;
        state_nxt = StIns2;
      end
      StIns2: begin
        cmd.op = CmdIns2;
        state_nxt = StDone;
      end
      StRem2: begin
        cmd.op = CmdRem2;
        state_nxt = StDone;
      end
      StDone: begin
        if (!vld_r || out_taken) begin
          vld_nxt = 1'b1;
          state_nxt = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StInit;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end

  assign in_rdy  = (state_r == StIdle) && !vld_r;
  assign out_vld = vld_r;
endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import idl_pkg::*;

  localparam int ModeBad = 3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_value;
    logic [8:0]  count;
  } list_result_t;

  // Shadow copy of the list contents, front first.
  logic [31:0]  shadow_list[$];
  list_result_t pending_results[$];
  int           error_count = 0;

  indexed_deque_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predict one result and update the shadow list.
  function automatic list_result_t apply_list_op(logic [1:0] mode, logic signed [9:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    int n;
    int idx;
    n = shadow_list.size();
    r = '0;
    if (mode == ModeRead || mode == ModeRemove) begin
      idx = (pos >= 0) ? int'(pos) : n + int'(pos);
      if (idx >= 0 && idx < n) begin
        r.ok = 1'b1;
        r.read_value = shadow_list[idx];
        if (mode == ModeRemove) shadow_list.delete(idx);
      end
    end else if (mode == ModeInsert && n < Capacity) begin
      // Insert point counted as the index the new element gets.
      if (pos >= 0) idx = int'(pos);
      else idx = n + 1 + int'(pos);
      if (idx >= 0 && idx <= n) begin
        r.ok = 1'b1;
        shadow_list.insert(idx, val);
      end
    end
    r.count = 9'(shadow_list.size());
    return r;
  endfunction

  task automatic send_item(logic [1:0] mode, logic signed [9:0] pos, logic [31:0] val);
    in_tdata  <= {4'd0, val, pos, mode};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_list_op(mode, pos, val));
    @(negedge clk);
    // Bursty sender: idle now and then.
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Result checking at the rising edge.
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[0], out_tdata[32:1], out_tdata[41:33]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok || got.read_value !== want.read_value ||
            got.count !== want.count) begin
          $display("%0t: mismatch, expected ok=%0b val=%h cnt=%0d actual ok=%0b val=%h cnt=%0d",
                   $time, want.ok, want.read_value, want.count,
                   got.ok, got.read_value, got.count);
          error_count++;
        end
      end
    end
  end

  // Receiver stall pattern: stretches of full rate and of random stalls.
  always @(negedge clk) begin
    int phase;
    phase = ($time / 40000) % 3;
    if (phase == 0) out_tready <= 1'b1;
    else if (phase == 1) out_tready <= ($urandom_range(0, 2) != 0);
    else out_tready <= ($urandom_range(0, 7) == 0);
  end

  typedef struct {
    logic [1:0]        mode;
    logic signed [9:0] pos;
    logic [31:0]       val;
  } list_stim_t;

  list_stim_t directed[22] = '{
    '{ModeRead,   10'sd0,    32'h0},
    '{ModeRemove, -10'sd1,   32'h0},
    '{ModeInsert, 10'sd1,    32'h5},
    '{ModeInsert, -10'sd2,   32'h5},
    '{ModeInsert, 10'sd0,    32'h8000_0000},
    '{ModeInsert, -10'sd1,   32'h7FFF_FFFF},
    '{ModeInsert, 10'sd2,    32'hFFFF_FFFF},
    '{ModeInsert, -10'sd2,   32'h0},
    '{ModeInsert, 10'sd1,    32'h1234_5678},
    '{ModeRead,   10'sd0,    32'hFFFF_FFFF},
    '{ModeRead,   -10'sd1,   32'h0},
    '{ModeRead,   10'sd255,  32'h0},
    '{ModeRead,   10'sd511,  32'h0},
    '{ModeRead,   10'sh200,  32'h0},
    '{ModeInsert, 10'sd256,  32'h1},
    '{ModeInsert, -10'sd257, 32'h1},
    '{2'(ModeBad), 10'sd0,   32'h0},
    '{ModeRemove, 10'sd2,    32'h0},
    '{ModeRemove, -10'sd2,   32'h0},
    '{ModeRemove, 10'sd0,    32'h0},
    '{ModeInsert, 10'sd1,    32'hA5A5_A5A5},
    '{ModeRead,   10'sd1,    32'h0}
  };

  initial begin
    int k;
    int w;
    logic [1:0] m;
    logic signed [9:0] p;
    int n;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_item(directed[i].mode, directed[i].pos, directed[i].val);

    // Fill to capacity, then overflow, then random, then drain.
    for (k = 0; k < 1300; k++) begin
      n = shadow_list.size();
      w = $urandom_range(0, 99);
      if (k < 260) m = ModeInsert;
      else if (k < 270) m = (k % 2) ? ModeInsert : ModeRead;
      else if (k > 1000 && n > 0 && w < 70) m = ModeRemove;
      else if (w < 2) m = 2'(ModeBad);
      else m = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) p = 10'($urandom);
      else if ($urandom_range(0, 1)) p = 10'($urandom_range(0, n));
      else p = -10'($urandom_range(1, n + 1));
      // Pause once until every expected result has come.
      if (k == 600) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end
      send_item(m, p, $urandom);
    end
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("indexed_deque_list test passed");
    end else begin
      $display("indexed_deque_list test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200ms;
    $display("indexed_deque_list test failed");
    $finish;
  end

endmodule
